// ----- src/pscx_pkg.sv -----
package pscx_pkg;

  // default key store depth
  localparam int KEY_DEPTH_DEF = 64;

  // printable byte window and its span
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [7:0] PRINT_SPAN = 8'd95;

  // request opcodes
  typedef enum logic [1:0] {
    OP_DATA      = 2'd0,
    OP_SHIFT_KEY = 2'd1,
    OP_XOR_KEY   = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_SHIFT_LEN = 2'd1,
    REG_XOR_LEN   = 2'd2
  } reg_idx_t;

  // per-request control for one key lane
  typedef struct packed {
    logic adv;  // key byte used, step position
    logic clr;  // end of message, position back to zero
  } lane_ctl_t;

endpackage

// ----- src/printable_shift_and_xor_cipher_unit.sv -----
// Byte cipher: printable bytes (32..126) are rotated modulo 95 by a repeating
// shift key, and every byte is XORed with a repeating XOR key unless its
// length is 0; encrypt runs shift then XOR, decrypt runs XOR then the negated
// shift. Key bytes are loaded by requests with op 1 (shift key) and op 2 (XOR
// key); op 0 carries data and gives one result, end_of_message returns both
// key positions to zero. A request is taken every cycle that in_ready is high:
// both key stores are prefetched from the next key position, so a result is
// registered in the cycle after its request. in_ready is low while a result
// waits with out_ready low, during the access cycle of a configuration write,
// and in the cycle after it while the prefetch follows the new lengths. Set
// lengths and mode over the APB port only with no request open.
module printable_shift_and_xor_cipher_unit #(
  parameter int KEY_DEPTH = pscx_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_value,
  input  logic [5:0]  key_slot,
  input  logic        end_of_message,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import pscx_pkg::*;

  logic       encrypt_mode;
  logic [6:0] shift_key_length;
  logic [6:0] xor_key_length;
  logic       cfg_wr;
  logic       cfg_wr_d;
  reg_idx_t   cfg_idx;
  logic       accept;
  logic       data_req;
  lane_ctl_t  shift_ctl;
  lane_ctl_t  xor_ctl;
  logic       shift_en;
  logic       xor_en;
  logic [6:0] shift_key;
  logic [7:0] xor_key;
  logic [7:0] res_byte;
  logic       shift_adv;
  logic       xor_adv;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_mode     <= 1'b1;
      shift_key_length <= '0;
      xor_key_length   <= '0;
      cfg_wr_d         <= 1'b0;
    end else begin
      cfg_wr_d <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MODE:      encrypt_mode     <= pwdata[0];
          REG_SHIFT_LEN: shift_key_length <= pwdata[6:0];
          REG_XOR_LEN:   xor_key_length   <= pwdata[6:0];
          default:       ;
        endcase
      end
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:      prdata = {31'd0, encrypt_mode};
      REG_SHIFT_LEN: prdata = {25'd0, shift_key_length};
      REG_XOR_LEN:   prdata = {25'd0, xor_key_length};
      default:       prdata = '0;
    endcase
  end

  // request handshake
  assign in_ready = !cfg_wr && !cfg_wr_d && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign data_req = accept && (op == OP_DATA);

  assign shift_ctl.adv = data_req && shift_adv;
  assign shift_ctl.clr = data_req && end_of_message;
  assign xor_ctl.adv   = data_req && xor_adv;
  assign xor_ctl.clr   = data_req && end_of_message;

  // key lanes
  pscx_key_lane #(
    .KEY_DEPTH (KEY_DEPTH),
    .DW        (7)
  ) u_shift_lane (
    .clk     (clk),
    .rst     (rst),
    .key_len (shift_key_length),
    .wr_en   (accept && (op == OP_SHIFT_KEY)),
    .wr_slot (key_slot),
    .wr_data (byte_value[6:0]),
    .ctl     (shift_ctl),
    .en      (shift_en),
    .key     (shift_key)
  );

  pscx_key_lane #(
    .KEY_DEPTH (KEY_DEPTH),
    .DW        (8)
  ) u_xor_lane (
    .clk     (clk),
    .rst     (rst),
    .key_len (xor_key_length),
    .wr_en   (accept && (op == OP_XOR_KEY)),
    .wr_slot (key_slot),
    .wr_data (byte_value),
    .ctl     (xor_ctl),
    .en      (xor_en),
    .key     (xor_key)
  );

  // byte transform
  pscx_cipher u_cipher (
    .encrypt   (encrypt_mode),
    .din       (byte_value),
    .shift_en  (shift_en),
    .shift_key (shift_key),
    .xor_en    (xor_en),
    .xor_key   (xor_key),
    .dout      (res_byte),
    .shift_adv (shift_adv),
    .xor_adv   (xor_adv)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= data_req;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_req) begin
      out_byte <= res_byte;
      out_last <= end_of_message;
    end
  end

  // checks
  a_cfg_bubble: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !in_ready)
    else $error("request taken right after a configuration write");

  a_data_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_DATA)) |=>
      (out_valid && (out_last == $past(end_of_message))))
    else $error("data request did not give its result");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op != OP_DATA)) |=> !out_valid)
    else $error("key request gave a result");

endmodule

// ----- src/pscx_ram.sv -----
module pscx_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pscx_key_lane.sv -----
module pscx_key_lane #(
  parameter int KEY_DEPTH = 64,
  parameter int DW        = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [6:0]          key_len,
  input  logic                wr_en,
  input  logic [5:0]          wr_slot,
  input  logic [DW-1:0]       wr_data,
  input  pscx_pkg::lane_ctl_t ctl,
  output logic                en,
  output logic [DW-1:0]       key
);
  import pscx_pkg::*;

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = $clog2(KEY_DEPTH + 1);
  localparam int CW = (LW > 7) ? LW : 7;

  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [LW-1:0] eff_len;
  logic [AW-1:0] cur_pos;
  logic [LW-1:0] pos_inc;
  logic [AW-1:0] step_pos;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] rdata;
  logic          byp_hit;
  logic [DW-1:0] byp_data;

  // length saturated to the store depth
  always_comb begin
    if (CW'(key_len) > CW'(KEY_DEPTH)) begin
      eff_len = LW'(KEY_DEPTH);
    end else begin
      eff_len = LW'(key_len);
    end
  end

  assign en = (eff_len != '0);

  // position in use, wrapped back when the length was lowered
  assign cur_pos  = (LW'(pos) < eff_len) ? pos : '0;
  assign pos_inc  = LW'(cur_pos) + LW'(1);
  assign step_pos = (pos_inc >= eff_len) ? '0 : AW'(pos_inc);

  always_comb begin
    if (ctl.clr) begin
      pos_next = '0;
    end else if (ctl.adv) begin
      pos_next = step_pos;
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // prefetch the key byte for the next request
  assign raddr = (LW'(pos_next) < eff_len) ? pos_next : '0;
  assign we    = wr_en && (int'(wr_slot) < KEY_DEPTH);
  assign waddr = AW'(wr_slot);

  pscx_ram #(
    .WIDTH (DW),
    .DEPTH (KEY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // forward a key write that lands on the prefetched entry
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= we && (waddr == raddr);
    end
    byp_data <= wr_data;
  end

  assign key = byp_hit ? byp_data : rdata;

endmodule

// ----- src/pscx_cipher.sv -----
module pscx_cipher (
  input  logic       encrypt,
  input  logic [7:0] din,
  input  logic       shift_en,
  input  logic [6:0] shift_key,
  input  logic       xor_en,
  input  logic [7:0] xor_key,
  output logic [7:0] dout,
  output logic       shift_adv,
  output logic       xor_adv
);
  import pscx_pkg::*;

  logic [7:0] amt_raw;
  logic [7:0] amt_a;
  logic [7:0] amt_b;
  logic [7:0] amt;
  logic [7:0] shift_in;
  logic [7:0] shift_out;
  logic [7:0] xor_first;
  logic [7:0] xor_out;
  logic [7:0] rot_sum;
  logic       printable;

  // (key - 32) mod 95, then negated for decrypt
  always_comb begin
    amt_raw = {1'b0, shift_key} + 8'd63;
    amt_a   = (amt_raw >= PRINT_SPAN) ? amt_raw - PRINT_SPAN : amt_raw;
    amt_b   = (amt_a >= PRINT_SPAN) ? amt_a - PRINT_SPAN : amt_a;
    if (encrypt || (amt_b == '0)) begin
      amt = amt_b;
    end else begin
      amt = PRINT_SPAN - amt_b;
    end
  end

  // decrypt applies the xor key ahead of the rotation
  assign xor_first = xor_en ? (din ^ xor_key) : din;
  assign shift_in  = encrypt ? din : xor_first;

  // rotate within the printable window
  always_comb begin
    printable = (shift_in >= PRINT_LOW) && (shift_in <= PRINT_HIGH);
    rot_sum   = (shift_in - PRINT_LOW) + amt;
    if (rot_sum >= PRINT_SPAN) begin
      rot_sum = rot_sum - PRINT_SPAN;
    end
    shift_adv = shift_en && printable;
    shift_out = shift_adv ? rot_sum + PRINT_LOW : shift_in;
  end

  // encrypt applies the xor key after the rotation
  assign xor_adv = xor_en;
  assign xor_out = xor_en ? (shift_out ^ xor_key) : shift_out;

  assign dout = encrypt ? xor_out : shift_out;

endmodule
